// ----- hw/rtl/b58_pkg.sv -----
`timescale 1ns / 1ps

package b58_pkg;

    localparam int unsigned MAX_OUT_BYTES_DEF = 64;
    localparam int unsigned B58_RADIX = 58;
    localparam int unsigned OB_REG_W = 8;
    localparam int unsigned OB_FIELD_W = 7;
    localparam logic [7:0] CHAR_ONE = "1";
    localparam logic [7:0] LEN_MAX = 8'hff;
    localparam logic REG_OUT_BYTES = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SER_IDLE,
        SER_ALIGN,
        SER_SCAN,
        SER_EMIT,
        SER_ERR
    } ser_state_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } digit_t;

    typedef struct packed {
        logic       valid;
        status_t    err;
        logic [7:0] lead;
    } fin_t;

    function automatic digit_t b58_digit(input logic [7:0] ch);
        digit_t d;
        d.ok = 1'b1;
        d.value = 6'd0;
        if (ch inside {["1":"9"]})
            d.value = 6'(ch - "1");
        else if (ch inside {["A":"H"]})
            d.value = 6'(ch - "A" + 8'd9);
        else if (ch inside {["J":"N"]})
            d.value = 6'(ch - "J" + 8'd17);
        else if (ch inside {["P":"Z"]})
            d.value = 6'(ch - "P" + 8'd22);
        else if (ch inside {["a":"k"]})
            d.value = 6'(ch - "a" + 8'd33);
        else if (ch inside {["m":"z"]})
            d.value = 6'(ch - "m" + 8'd44);
        else
            d.ok = 1'b0;
        return d;
    endfunction

endpackage

// ----- hw/rtl/b58_ifs.sv -----
`timescale 1ns / 1ps

interface b58_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       char_last;

    modport source (output valid, output text_char, output char_last, input ready);
    modport sink (input valid, input text_char, input char_last, output ready);
endinterface

interface b58_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [7:0] decoded_length;
    logic       result_last;

    modport source (output valid, output out_byte, output status, output decoded_length,
                    output result_last, input ready);
    modport sink (input valid, input out_byte, input status, input decoded_length,
                  input result_last, output ready);
endinterface

// ----- hw/rtl/b58_cfg_apb.sv -----
`timescale 1ns / 1ps

module b58_cfg_apb
    import b58_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CNT_W-1:0] n_eff
);

    logic [OB_REG_W-1:0] out_bytes_reg;
    logic [OB_REG_W-1:0] out_bytes_next;
    logic                sel_ob;

    assign sel_ob = paddr[2] == REG_OUT_BYTES;
    assign pready = 1'b1;

    always_comb
    begin
        out_bytes_next = out_bytes_reg;
        if (psel && penable && pwrite && sel_ob)
            out_bytes_next = OB_REG_W'(pwdata[OB_FIELD_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_bytes_reg <= OB_REG_W'(MAX_OUT_BYTES);
        else
            out_bytes_reg <= out_bytes_next;
    end

    assign prdata = sel_ob ? 32'(out_bytes_reg) : 32'd0;

    // zero acts as one, oversize clamps to the buffer size
    always_comb
    begin
        if (out_bytes_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(out_bytes_reg) > int'(MAX_OUT_BYTES))
            n_eff = CNT_W'(MAX_OUT_BYTES);
        else
            n_eff = CNT_W'(out_bytes_reg);
    end

endmodule

// ----- hw/rtl/b58_accum.sv -----
`timescale 1ns / 1ps

module b58_accum
    import b58_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1),
    localparam int unsigned ACC_BYTES = ((MAX_OUT_BYTES + 3) / 4) * 4,
    localparam int unsigned ACC_W = ACC_BYTES * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    b58_char_if.sink         chars,
    input  logic [CNT_W-1:0] n_eff,
    input  logic             ser_idle,
    output fin_t             fin,
    output logic [ACC_W-1:0] fin_acc
);

    localparam int unsigned PROD_W = ACC_W + 6;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [7:0]        lead_reg;
    logic [7:0]        lead_next;
    logic              pre_reg;
    logic              pre_next;
    status_t           err_reg;
    status_t           err_next;
    status_t           err_fin;
    logic [PROD_W-1:0] prod;
    logic              carry;
    logic              upd;
    logic              fits;
    logic              accept;
    digit_t            dg;

    assign chars.ready = !chars.char_last || ser_idle;
    assign accept = chars.valid && chars.ready;
    assign dg = b58_digit(chars.text_char);

    assign prod = PROD_W'(acc_reg) * PROD_W'(B58_RADIX) + PROD_W'(dg.value);
    assign carry = |prod[PROD_W-1:ACC_W];

    always_comb
    begin
        acc_next = acc_reg;
        lead_next = lead_reg;
        pre_next = pre_reg;
        err_next = err_reg;
        upd = 1'b0;
        if (err_reg == ST_OK)
        begin
            if (pre_reg && chars.text_char == CHAR_ONE)
            begin
                if (lead_reg != LEN_MAX)
                    lead_next = lead_reg + 8'd1;
            end
            else
            begin
                pre_next = 1'b0;
                if (!dg.ok)
                    err_next = ST_INVALID;
                else
                begin
                    acc_next = prod[ACC_W-1:0];
                    upd = 1'b1;
                end
            end
        end
    end

    // no nonzero byte at or above byte n_eff, the effective output size
    always_comb
    begin
        fits = 1'b1;
        for (int i = 0; i < int'(ACC_BYTES); i++)
        begin
            if (i >= int'(n_eff) && (|acc_next[i*8 +: 8]))
                fits = 1'b0;
        end
    end

    always_comb
    begin
        err_fin = err_next;
        if (err_next == ST_OK && ((upd && carry) || ((upd || chars.char_last) && !fits)))
            err_fin = ST_OVERFLOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            lead_reg <= '0;
            pre_reg <= 1'b1;
            err_reg <= ST_OK;
        end
        else if (accept)
        begin
            if (chars.char_last)
            begin
                acc_reg <= '0;
                lead_reg <= '0;
                pre_reg <= 1'b1;
                err_reg <= ST_OK;
            end
            else
            begin
                acc_reg <= acc_next;
                lead_reg <= lead_next;
                pre_reg <= pre_next;
                err_reg <= err_fin;
            end
        end
    end

    assign fin.valid = accept && chars.char_last;
    assign fin.err = err_fin;
    assign fin.lead = lead_next;
    assign fin_acc = acc_next;

endmodule

// ----- hw/rtl/b58_serial.sv -----
`timescale 1ns / 1ps

module b58_serial
    import b58_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1),
    localparam int unsigned ACC_BYTES = ((MAX_OUT_BYTES + 3) / 4) * 4,
    localparam int unsigned ACC_W = ACC_BYTES * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fin_t             fin,
    input  logic [ACC_W-1:0] fin_acc,
    input  logic [CNT_W-1:0] n_eff,
    output logic             ser_idle,
    b58_res_if.source        results
);

    localparam int unsigned BUF_W = MAX_OUT_BYTES * 8;
    localparam int unsigned SUM_W = 9;

    ser_state_t         state_reg;
    ser_state_t         state_next;
    logic [BUF_W-1:0]   buf_reg;
    logic [BUF_W-1:0]   buf_next;
    logic [MAX_OUT_BYTES-1:0] nz_reg;
    logic [MAX_OUT_BYTES-1:0] nz_next;
    logic [MAX_OUT_BYTES-1:0] nz_load;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic [7:0]         lead_reg;
    logic [7:0]         lead_next;
    status_t            err_reg;
    status_t            err_next;
    logic [7:0]         len_reg;
    logic [7:0]         len_next;
    logic [SUM_W-1:0]   len_sum;
    logic               scan_done;
    logic               out_take;

    always_comb
    begin
        for (int i = 0; i < int'(MAX_OUT_BYTES); i++)
            nz_load[i] = |fin_acc[i*8 +: 8];
    end

    assign out_take = results.valid && results.ready;
    assign scan_done = nz_reg[MAX_OUT_BYTES-1] || cnt_reg == n_reg;
    assign len_sum = SUM_W'(n_reg - cnt_reg) + SUM_W'(lead_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SER_IDLE:
            begin
                if (fin.valid)
                begin
                    if (fin.err != ST_OK)
                        state_next = SER_ERR;
                    else if (n_eff == CNT_W'(MAX_OUT_BYTES))
                        state_next = SER_SCAN;
                    else
                        state_next = SER_ALIGN;
                end
            end
            SER_ALIGN:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = SER_SCAN;
            end
            SER_SCAN:
            begin
                if (scan_done)
                    state_next = SER_EMIT;
            end
            SER_EMIT:
            begin
                if (out_take && cnt_reg == CNT_W'(1))
                    state_next = SER_IDLE;
            end
            SER_ERR:
            begin
                if (out_take)
                    state_next = SER_IDLE;
            end
            default:
                state_next = SER_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        buf_next = buf_reg;
        nz_next = nz_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        lead_next = lead_reg;
        err_next = err_reg;
        len_next = len_reg;
        case (state_reg)
            SER_IDLE:
            begin
                if (fin.valid)
                begin
                    buf_next = fin_acc[BUF_W-1:0];
                    nz_next = nz_load;
                    n_next = n_eff;
                    lead_next = fin.lead;
                    err_next = fin.err;
                    if (n_eff == CNT_W'(MAX_OUT_BYTES))
                        cnt_next = '0;
                    else
                        cnt_next = CNT_W'(MAX_OUT_BYTES) - n_eff;
                end
            end
            SER_ALIGN:
            begin
                // bring byte n-1 to the top
                buf_next = buf_reg << 8;
                nz_next = nz_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            SER_SCAN:
            begin
                if (scan_done)
                begin
                    len_next = (len_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : len_sum[7:0];
                    cnt_next = n_reg;
                end
                else
                begin
                    nz_next = nz_reg << 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            SER_EMIT:
            begin
                if (out_take)
                begin
                    buf_next = buf_reg << 8;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            SER_ERR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SER_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        nz_reg <= nz_next;
        n_reg <= n_next;
        lead_reg <= lead_next;
        err_reg <= err_next;
        len_reg <= len_next;
    end

    // outputs
    always_comb
    begin
        ser_idle = 1'b0;
        results.valid = 1'b0;
        results.out_byte = buf_reg[BUF_W-1 -: 8];
        results.status = ST_OK;
        results.decoded_length = len_reg;
        results.result_last = 1'b0;
        case (state_reg)
            SER_IDLE:
                ser_idle = 1'b1;
            SER_EMIT:
            begin
                results.valid = 1'b1;
                results.result_last = cnt_reg == CNT_W'(1);
            end
            SER_ERR:
            begin
                results.valid = 1'b1;
                results.out_byte = 8'd0;
                results.status = err_reg;
                results.decoded_length = 8'd0;
                results.result_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/base58_text_decoder.sv -----
`timescale 1ns / 1ps
// character words fold into the accumulator when accepted, one word per cycle while ready
// final character: the result buffer is shifted byte-wise until byte n-1 is at the top,
// n being out_bytes clamped to 1..MAX_OUT_BYTES, then scanned for its leading zero bytes;
// then one byte per cycle while the sink is ready; an error word follows in the next cycle
// a final character waits for the previous text's results to drain
// reset clears the accumulator and prefix state and sets out_bytes to MAX_OUT_BYTES

module base58_text_decoder
    import b58_pkg::*;
#(
    parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    b58_char_if.sink    chars,
    b58_res_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNT_W = $clog2(MAX_OUT_BYTES + 1);
    localparam int unsigned ACC_W = ((MAX_OUT_BYTES + 3) / 4) * 32;

    logic [CNT_W-1:0] n_eff;
    logic             ser_idle;
    fin_t             fin;
    logic [ACC_W-1:0] fin_acc;

    b58_cfg_apb #(
        .MAX_OUT_BYTES(MAX_OUT_BYTES)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .n_eff(n_eff)
    );

    b58_accum #(
        .MAX_OUT_BYTES(MAX_OUT_BYTES)
    ) u_accum (
        .clk(clk),
        .rst_n(rst_n),
        .chars(chars),
        .n_eff(n_eff),
        .ser_idle(ser_idle),
        .fin(fin),
        .fin_acc(fin_acc)
    );

    b58_serial #(
        .MAX_OUT_BYTES(MAX_OUT_BYTES)
    ) u_serial (
        .clk(clk),
        .rst_n(rst_n),
        .fin(fin),
        .fin_acc(fin_acc),
        .n_eff(n_eff),
        .ser_idle(ser_idle),
        .results(results)
    );

endmodule

// ----- hw/rtl/b58_checker.sv -----
`timescale 1ns / 1ps

module b58_checker
    import b58_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte,
    input logic [1:0] res_status,
    input logic [7:0] res_decoded_length,
    input logic       res_result_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_byte))
        else $error("result word dropped or changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |->
            res_result_last && res_out_byte == 8'd0 && res_decoded_length == 8'd0)
        else $error("error result is not a single zero word");

    a_len_steady: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_result_last |=>
            res_valid && $stable(res_decoded_length) && res_status == ST_OK)
        else $error("length or status changed inside a result burst");

endmodule

bind base58_text_decoder b58_checker u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(results.valid),
    .res_ready(results.ready),
    .res_out_byte(results.out_byte),
    .res_status(results.status),
    .res_decoded_length(results.decoded_length),
    .res_result_last(results.result_last)
);

// ----- tb/base58_text_decoder_tb.sv -----
`timescale 1ns / 1ps

module base58_text_decoder_tb;
    import b58_pkg::*;

    localparam int MAXB = MAX_OUT_BYTES_DEF;
    localparam int SETTLE_CYCLES = 2 * MAXB + 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    typedef struct {
        logic [7:0] data;
        status_t    status;
        logic [7:0] len;
        logic       last;
    } byte_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b58_char_if chars_if ();
    b58_res_if  res_if ();

    base58_text_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder model state
    logic [MAXB*8-1:0] acc_val;
    logic [7:0]        ones_cnt;
    logic              in_prefix;
    status_t           err_code;
    logic [6:0]        size_reg;

    char_word_t char_backlog[$];
    byte_word_t expected_bytes[$];
    int         chars_queued = 0;
    int         errors = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    string      b58_chars = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("** base58_text_decoder: FAILED **");
        $finish;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", msg);
    endtask

    function automatic int char_digit(input logic [7:0] ch);
        int c;
        c = ch;
        if (c >= "1" && c <= "9") return c - "1";
        if (c >= "A" && c <= "H") return c - "A" + 9;
        if (c >= "J" && c <= "N") return c - "J" + 17;
        if (c >= "P" && c <= "Z") return c - "P" + 22;
        if (c >= "a" && c <= "k") return c - "a" + 33;
        if (c >= "m" && c <= "z") return c - "m" + 44;
        return -1;
    endfunction

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAXB) return MAXB;
        return size_reg;
    endfunction

    function automatic bit acc_fits(input int n);
        return (acc_val >> (8 * n)) == '0;
    endfunction

    task automatic clear_text();
        acc_val = '0;
        ones_cnt = '0;
        in_prefix = 1'b1;
        err_code = ST_OK;
    endtask

    // fold one accepted character and queue the bytes it produces
    task automatic fold_char(input logic [7:0] ch, input logic last);
        int n;
        int d;
        int zeros;
        int len;
        logic [MAXB*8+7:0] wide;
        byte_word_t r;
        n = eff_size();
        if (err_code == ST_OK)
        begin
            if (in_prefix && ch == CHAR_ONE)
            begin
                if (ones_cnt != LEN_MAX)
                    ones_cnt++;
            end
            else
            begin
                d = char_digit(ch);
                in_prefix = 1'b0;
                if (d < 0)
                    err_code = ST_INVALID;
                else
                begin
                    wide = {8'd0, acc_val} * B58_RADIX + d;
                    acc_val = wide[MAXB*8-1:0];
                    if (wide[MAXB*8+7:MAXB*8] != 0 || !acc_fits(n))
                        err_code = ST_OVERFLOW;
                end
            end
        end
        if (!last)
            return;
        if (err_code == ST_OK && !acc_fits(n))
            err_code = ST_OVERFLOW;
        if (err_code != ST_OK)
        begin
            r.data = 8'd0;
            r.status = err_code;
            r.len = 8'd0;
            r.last = 1'b1;
            expected_bytes.push_back(r);
        end
        else
        begin
            zeros = 0;
            while (zeros < n && acc_val[(n - 1 - zeros) * 8 +: 8] == 8'd0)
                zeros++;
            len = n - zeros + ones_cnt;
            if (len > 255)
                len = 255;
            for (int k = 0; k < n; k++)
            begin
                r.data = acc_val[(n - 1 - k) * 8 +: 8];
                r.status = ST_OK;
                r.len = 8'(len);
                r.last = (k == n - 1);
                expected_bytes.push_back(r);
            end
        end
        clear_text();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        char_word_t w;
        if (!rst_n)
        begin
            chars_if.valid <= 1'b0;
            chars_if.text_char <= 8'd0;
            chars_if.char_last <= 1'b0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
                fold_char(chars_if.text_char, chars_if.char_last);
            if (!chars_if.valid || chars_if.ready)
            begin
                if (char_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    w = char_backlog.pop_front();
                    chars_if.valid <= 1'b1;
                    chars_if.text_char <= w.ch;
                    chars_if.char_last <= w.last;
                end
                else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_bytes
        byte_word_t e;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_bytes.size() == 0)
                    report($sformatf("unexpected byte %02h status %0d len %0d last %0b",
                                     res_if.out_byte, res_if.status, res_if.decoded_length,
                                     res_if.result_last));
                else
                begin
                    e = expected_bytes.pop_front();
                    if (res_if.out_byte != e.data || res_if.status != e.status
                        || res_if.decoded_length != e.len || res_if.result_last != e.last)
                        report($sformatf("got %02h/%0d/%0d/%0b expected %02h/%0d/%0d/%0b",
                                         res_if.out_byte, res_if.status,
                                         res_if.decoded_length, res_if.result_last,
                                         e.data, e.status, e.len, e.last));
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic push_char(input logic [7:0] ch, input logic last);
        char_word_t w;
        w.ch = ch;
        w.last = last;
        char_backlog.push_back(w);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic add_random_text(input int n);
        int kind;
        int ones;
        int digits;
        logic [7:0] c;
        logic [7:0] txt[$];
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            repeat ($urandom_range(1, 4))
                txt.push_back(8'($urandom));
        end
        else
        begin
            ones = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            digits = (kind == 9) ? 0 : $urandom_range(0, n * 3 / 2 + 2);
            if (kind == 9 && ones == 0)
                ones = 1;
            repeat (ones)
                txt.push_back(CHAR_ONE);
            repeat (digits)
                txt.push_back(b58_chars[$urandom_range(0, 57)]);
            if (txt.size() == 0)
                txt.push_back(b58_chars[$urandom_range(1, 57)]);
            if (kind == 8)
            begin
                do
                    c = 8'($urandom);
                while (char_digit(c) >= 0);
                txt.insert($urandom_range(0, txt.size()), c);
            end
        end
        foreach (txt[i])
            push_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (char_backlog.size() != 0 || chars_if.valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [6:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_OUT_BYTES, 2'b00};
        pwdata <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        size_reg = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_phase(input logic [6:0] v, input int src_pct, input int snk_pct,
                                input int nchars);
        int target;
        wait_drained();
        write_size(v);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target = chars_queued + nchars;
        while (chars_queued < target)
            add_random_text(eff_size());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        chars_if.valid = 1'b0;
        chars_if.text_char = 8'd0;
        chars_if.char_last = 1'b0;
        res_if.ready = 1'b0;
        clear_text();
        size_reg = 7'(MAXB);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // buffer size at its reset value
        push_text("1");
        push_text("z");
        push_text("11z");
        push_text("0");
        push_text("I");
        push_text("O");
        push_text("l");
        push_char(8'hff, 1'b1);
        push_char(8'h00, 1'b1);
        push_char(8'h80, 1'b0);
        push_char("2", 1'b1);
        push_text("z!");

        // size shrinks in the middle of a text
        push_char("z", 1'b0);
        push_char("z", 1'b0);
        wait_drained();
        write_size(7'd2);
        push_char("z", 1'b1);

        // single byte buffer, edge of overflow
        wait_drained();
        write_size(7'd1);
        push_text("5Q");
        push_text("5R");
        push_text("1115Q");

        random_phase(7'd4, 0, 0, 12);
        random_phase(7'd1, 56, 0, 12);
        random_phase(7'd127, 0, 56, 16);
        random_phase(7'($urandom_range(2, 16)), 37, 37, 12);
        random_phase(7'd0, 0, 0, 8);
        // leading ones counter and length both saturate
        repeat (256)
            push_char(CHAR_ONE, 1'b0);
        push_char("z", 1'b1);
        random_phase(7'($urandom_range(1, 64)), 0, 0, 8);

        wait_drained();
        if (errors == 0)
            $display("** base58_text_decoder: PASSED **");
        else
            $display("** base58_text_decoder: FAILED **");
        $finish;
    end

endmodule
